// ===== rtl/windowed_filtered_bucket_count_assert.svh =====
// Assertion macros shared by the windowed bucket counter.
`ifndef WINDOWED_FILTERED_BUCKET_COUNT_ASSERT_SVH
`define WINDOWED_FILTERED_BUCKET_COUNT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define WFBC_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define WFBC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/wfbc_pkg.sv =====
// Types and constants shared by the windowed bucket counter modules.
package wfbc_pkg;

  // Event word of a view event, the bytes "view" read little-endian.
  localparam logic [31:0] VIEW_WORD = 32'd2003134838;
  localparam logic [63:0] HASH_MUL  = 64'd789;
  localparam logic [63:0] HASH_ADD  = 64'd321;

  // Bucket values are carried 16 bits wide; results carry the low 14 bits.
  localparam int BKT_W = 16;
  localparam int OUT_BKT_W = 14;

  // A classified item on its way from the front to the back.
  typedef struct packed {
    logic              kind;
    logic              view;
    logic              in_range;
    logic              on_boundary;
    logic [BKT_W-1:0]  bucket;
    logic [31:0]       now;
  } wfbc_item_t;

endpackage

// ===== rtl/wfbc_front.sv =====
// Front part: accepts items, hashes the key and reduces hash and time modulo.
module wfbc_front #(
  parameter int MAX_BUCKETS = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [143:0]        s_tdata,
  input  logic                s_tuser,
  input  logic [15:0]         window_seconds,
  input  logic [14:0]         bucket_count,
  output logic                q_valid,
  input  logic                q_ready,
  output wfbc_pkg::wfbc_item_t q_item
);
  import wfbc_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]  state;
  logic [5:0]  step;
  logic        kind;
  logic [31:0] word;
  logic [63:0] key;
  logic [31:0] now;
  logic [13:0] rb;
  logic [63:0] h_sh;
  logic [31:0] t_sh;
  logic [15:0] rem_h;
  logic [15:0] rem_t;
  logic [16:0] nb;
  logic [16:0] ws;
  logic [16:0] h_try;
  logic [16:0] t_try;
  logic [16:0] h_red;
  logic [16:0] t_red;

  // Effective modulus values after clamping the register values.
  always_comb begin
    if (bucket_count == 15'd0) begin
      nb = 17'd1;
    end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
      nb = 17'(MAX_BUCKETS);
    end else begin
      nb = 17'(bucket_count);
    end
    ws = (window_seconds == 16'd0) ? 17'd1 : {1'b0, window_seconds};
  end

  // One restoring division step for each remainder.
  always_comb begin
    h_try = {rem_h, h_sh[63]};
    h_red = (h_try >= nb) ? h_try - nb : h_try;
    t_try = {rem_t, t_sh[31]};
    t_red = (t_try >= ws) ? t_try - ws : t_try;
  end

  assign s_tready = (state == F_IDLE);
  assign q_valid  = (state == F_PUSH);

  always_comb begin
    q_item.kind        = kind;
    q_item.view        = (word == VIEW_WORD);
    q_item.in_range    = (17'(rb) < nb);
    q_item.on_boundary = (rem_t == 16'd0);
    q_item.bucket      = kind ? BKT_W'(rb) : rem_h;
    q_item.now         = now;
  end

  // Sequencer: multiply, then 64 division steps, then hand over.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            state <= F_MUL;
          end
        end
        F_MUL: begin
          state <= F_DIV;
          step  <= '0;
        end
        F_DIV: begin
          step <= step + 6'd1;
          if (step == 6'd63) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == F_IDLE && s_tvalid) begin
      word <= s_tdata[31:0];
      key  <= s_tdata[95:32];
      now  <= s_tdata[127:96];
      rb   <= s_tdata[141:128];
      kind <= s_tuser;
    end
    if (state == F_MUL) begin
      h_sh  <= key * HASH_MUL + HASH_ADD;
      t_sh  <= now;
      rem_h <= '0;
      rem_t <= '0;
    end
    if (state == F_DIV) begin
      h_sh  <= {h_sh[62:0], 1'b0};
      rem_h <= h_red[15:0];
      if (step[5]) begin
        t_sh  <= {t_sh[30:0], 1'b0};
        rem_t <= t_red[15:0];
      end
    end
  end

endmodule

// ===== rtl/wfbc_queue.sv =====
// Two-entry queue that decouples the front from the back.
module wfbc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wfbc_pkg::wfbc_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wfbc_pkg::wfbc_item_t out_item
);
  import wfbc_pkg::*;

  wfbc_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== rtl/wfbc_back.sv =====
// Back part: window control, count memory update and the result register.
module wfbc_back #(
  parameter int MAX_BUCKETS = 16384
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  wfbc_pkg::wfbc_item_t q_item,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata
);
  import wfbc_pkg::*;

  localparam int DEPTH = 2 * MAX_BUCKETS;
  localparam int AD_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [32:0]     mem [DEPTH];
  logic [32:0]     rd_q;
  logic [2:0]      state;
  logic [AD_W-1:0] sweep;
  logic            table_sel;
  logic            time_seen;
  logic [31:0]     last_switch;
  wfbc_item_t      cur;
  logic            sw_flag;
  logic [AD_W-1:0] base;
  logic [AD_W-1:0] rd_addr;
  logic            wr_en;
  logic [AD_W-1:0] wr_addr;
  logic [32:0]     wr_data;
  logic [31:0]     old_cnt;
  logic [31:0]     new_cnt;
  logic            o_acc;
  logic            o_sw;
  logic            o_tab;
  logic [13:0]     o_bkt;
  logic [31:0]     o_cnt;

  assign base    = table_sel ? AD_W'(MAX_BUCKETS) : '0;
  assign rd_addr = base + AD_W'(cur.bucket);
  assign q_ready = (state == S_IDLE) && !m_tvalid;
  assign old_cnt = rd_q[32] ? rd_q[31:0] : 32'd0;
  assign new_cnt = (old_cnt == 32'hFFFF_FFFF) ? old_cnt : old_cnt + 32'd1;
  assign m_tdata = {7'd0, o_cnt, o_bkt, o_tab, o_sw, o_acc};

  // Memory write selection: clearing sweeps or a count update.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = {1'b1, new_cnt};
    if (state == S_INIT) begin
      wr_en   = 1'b1;
      wr_addr = sweep;
      wr_data = '0;
    end else if (state == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = base + sweep;
      wr_data = '0;
    end else if (state == S_UPD && !cur.kind) begin
      wr_en = 1'b1;
    end
  end

  // Count memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Control sequencer and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep       <= '0;
      table_sel   <= 1'b0;
      time_seen   <= 1'b0;
      last_switch <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          sweep <= sweep + AD_W'(1);
          if (sweep == AD_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid && !m_tvalid) begin
            if (q_item.kind) begin
              if (q_item.in_range) begin
                state <= S_RD;
              end else begin
                m_tvalid <= 1'b1;
              end
            end else if (!q_item.view) begin
              m_tvalid <= 1'b1;
            end else if (!time_seen) begin
              time_seen   <= 1'b1;
              last_switch <= q_item.now;
              state       <= S_RD;
            end else if (q_item.now != last_switch && q_item.on_boundary) begin
              table_sel   <= ~table_sel;
              last_switch <= q_item.now;
              sweep       <= '0;
              state       <= S_CLR;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_CLR: begin
          sweep <= sweep + AD_W'(1);
          if (sweep == AD_W'(MAX_BUCKETS - 1)) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && !m_tvalid) begin
      cur <= q_item;
      sw_flag <= !q_item.kind && q_item.view && time_seen &&
                 q_item.now != last_switch && q_item.on_boundary;
      o_acc <= 1'b0;
      o_sw  <= 1'b0;
      o_tab <= table_sel;
      o_bkt <= q_item.kind ? q_item.bucket[OUT_BKT_W-1:0] : '0;
      o_cnt <= '0;
    end
    if (state == S_UPD) begin
      o_tab <= table_sel;
      o_bkt <= cur.bucket[OUT_BKT_W-1:0];
      if (cur.kind) begin
        o_cnt <= old_cnt;
      end else begin
        o_acc <= 1'b1;
        o_sw  <= sw_flag;
        o_cnt <= new_cnt;
      end
    end
  end

endmodule

// ===== rtl/windowed_filtered_bucket_count.sv =====
// Top level of the windowed bucket counter: config registers, front, queue, back.
//
// View events are hashed to a bucket and counted in one of two tumbling window
// tables; read items return a bucket count of the current window. The front
// handles one item at a time: it captures the item, multiplies, and runs a
// 64-step shift-subtract unit that reduces the hash modulo the bucket count and
// the time modulo the window length. The back looks up each view event and
// in-range read in the count memory (one write port, one registered read port)
// and clears the MAX_BUCKETS entries of the new table on a window switch.
// A two-entry queue lets the front work on the next item while the back updates
// memory or a result waits on the output. After reset a clearing pass over all
// 2*MAX_BUCKETS entries of the count memory runs before the first item is
// counted; configuration writes are taken throughout.
module windowed_filtered_bucket_count #(
  parameter int MAX_BUCKETS = 16384
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata fields from bit 0: event_word, campaign_key, now_seconds, read_bucket
  input  logic [143:0] s_tdata,
  // s_tuser fields from bit 0: kind
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata fields from bit 0: accepted, window_switched, active_table, bucket,
  // count_value
  output logic [55:0]  m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  import wfbc_pkg::*;

  localparam logic REG_WINDOW_SECONDS = 1'b0;
  localparam logic REG_BUCKET_COUNT   = 1'b1;

  logic [15:0] window_seconds;
  logic [14:0] bucket_count;
  logic        fq_valid;
  logic        fq_ready;
  wfbc_item_t  fq_item;
  logic        qb_valid;
  logic        qb_ready;
  wfbc_item_t  qb_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= 16'd5;
      bucket_count   <= 15'd10000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SECONDS: window_seconds <= cfg_data;
        REG_BUCKET_COUNT:   bucket_count   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  wfbc_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .window_seconds (window_seconds),
    .bucket_count   (bucket_count),
    .q_valid        (fq_valid),
    .q_ready        (fq_ready),
    .q_item         (fq_item)
  );

  wfbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  wfbc_back #(.MAX_BUCKETS(MAX_BUCKETS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_item   (qb_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `include "windowed_filtered_bucket_count_assert.svh"

  // A switch happens only on a counted record.
  `WFBC_ASSERT_NOW(a_switch_counted, m_tvalid && m_tdata[1], m_tdata[0], "switch on uncounted item")
  // A counted record never leaves a zero count.
  `WFBC_ASSERT_NOW(a_count_nonzero, m_tvalid && m_tdata[0], m_tdata[48:17] != 32'd0, "zero count")
  // The front takes one item at a time.
  `WFBC_ASSERT_NEXT(a_front_busy, s_tvalid && s_tready, !s_tready, "front took two items")

endmodule

// ===== tb/tb_windowed_filtered_bucket_count.sv =====
// Self-checking testbench for the windowed view-event bucket counter.
module tb_windowed_filtered_bucket_count;

  localparam int NBKT = 16384;
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_READ  = 1'b1;
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_BUCKETS = 1'b1;
  localparam logic [31:0] VIEW = wfbc_pkg::VIEW_WORD;

  // One input transaction, packed the way s_tdata carries it.
  typedef struct packed {
    logic [13:0] read_bucket;
    logic [31:0] now_seconds;
    logic [63:0] campaign_key;
    logic [31:0] event_word;
  } rec_data_t;

  typedef struct {
    logic      kind;
    rec_data_t data;
  } rec_t;

  // One result transaction, packed the way m_tdata carries it.
  typedef struct packed {
    logic [31:0] count_value;
    logic [13:0] bucket;
    logic        active_table;
    logic        window_switched;
    logic        accepted;
  } count_res_t;

  // Tracks the two window tables and holds the counts still to be seen.
  class count_scoreboard;
    int unsigned  win_len = 5;
    int unsigned  nbuckets = 10000;
    bit           cur_table;
    logic [31:0]  last_switch;
    bit           seen_time;
    bit           valid_bits[2*NBKT];
    bit           written[2*NBKT];
    logic [31:0]  counts[2*NBKT];
    int           last_bucket = -1;
    int           errors;
    int           n_checked, n_switches, n_views, n_reads;
    count_res_t   pending_counts[$];

    function int unsigned eff_buckets();
      if (nbuckets == 0) return 1;
      if (nbuckets > NBKT) return NBKT;
      return nbuckets;
    endfunction

    function logic [31:0] lookup(int unsigned b);
      int unsigned idx;
      idx = cur_table * NBKT + b;
      return valid_bits[idx] ? counts[idx] : 32'd0;
    endfunction

    // Predict the result of an accepted input transaction.
    function void note_input(rec_t it);
      count_res_t r;
      int unsigned nb, ws, b;
      logic [63:0] h;
      nb = eff_buckets();
      r = '0;
      if (it.kind == KIND_READ) begin
        n_reads++;
        r.bucket = it.data.read_bucket;
        r.count_value = (it.data.read_bucket < nb) ? lookup(it.data.read_bucket) : 32'd0;
      end else if (it.data.event_word == VIEW) begin
        n_views++;
        ws = (win_len == 0) ? 1 : win_len;
        r.accepted = 1'b1;
        if (!seen_time) begin
          seen_time = 1'b1;
          last_switch = it.data.now_seconds;
        end else if (it.data.now_seconds != last_switch &&
                     (it.data.now_seconds % ws) == 0) begin
          cur_table = ~cur_table;
          for (int i = 0; i < NBKT; i++) valid_bits[cur_table*NBKT + i] = 1'b0;
          last_switch = it.data.now_seconds;
          r.window_switched = 1'b1;
          n_switches++;
        end
        h = it.data.campaign_key * 64'd789 + 64'd321;
        b = 32'(h % nb);
        r.bucket = 14'(b);
        r.count_value = lookup(b);
        if (r.count_value != 32'hFFFF_FFFF) r.count_value++;
        counts[cur_table*NBKT + b] = r.count_value;
        valid_bits[cur_table*NBKT + b] = 1'b1;
        written[cur_table*NBKT + b] = 1'b1;
        last_bucket = int'(b);
      end
      r.active_table = cur_table;
      pending_counts.push_back(r);
    endfunction

    // Compare a result transaction with the oldest prediction.
    function void check_result(count_res_t got);
      count_res_t e;
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending_counts.pop_front();
      n_checked++;
      if (got.accepted !== e.accepted) begin
        $display("%0t: accepted exp %0d got %0d", $time, e.accepted, got.accepted);
        errors++;
      end
      if (got.window_switched !== e.window_switched) begin
        $display("%0t: window_switched exp %0d got %0d", $time, e.window_switched,
                 got.window_switched);
        errors++;
      end
      if (got.active_table !== e.active_table) begin
        $display("%0t: active_table exp %0d got %0d", $time, e.active_table,
                 got.active_table);
        errors++;
      end
      if (got.bucket !== e.bucket) begin
        $display("%0t: bucket exp %0d got %0d", $time, e.bucket, got.bucket);
        errors++;
      end
      if (got.count_value !== e.count_value) begin
        $display("%0t: count_value exp %0d got %0d", $time, e.count_value,
                 got.count_value);
        errors++;
      end
    endfunction
  endclass

  logic         clk, rst;
  logic         s_tvalid, s_tready, s_tuser;
  logic [143:0] s_tdata;
  logic         m_tvalid, m_tready;
  logic [55:0]  m_tdata;
  logic         cfg_we, cfg_index;
  logic [15:0]  cfg_data;

  count_scoreboard sb;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_req;
  logic [63:0] key_pool[8];

  windowed_filtered_bucket_count uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung run.
  initial begin
    #60000000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: check each result transaction, then choose tready for the next cycle.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(count_res_t'(m_tdata[48:0]));
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one input transaction and wait until the block takes it.
  task automatic send_rec(rec_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = it.kind;
    s_tdata = {2'b00, it.data};
    do @(posedge clk); while (!s_tready);
    sb.note_input(it);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_WINDOW) sb.win_len = 32'(val);
    else sb.nbuckets = 32'(val[14:0]);
  endtask

  // Let every predicted count arrive, then let the back end settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending_counts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic rec_t mk_rec(logic kind, logic [31:0] word, logic [63:0] key,
                                  logic [31:0] now, logic [13:0] rb);
    rec_t it;
    it.kind = kind;
    it.data.event_word = word;
    it.data.campaign_key = key;
    it.data.now_seconds = now;
    it.data.read_bucket = rb;
    return it;
  endfunction

  // Random time that only rarely opens a new window, since each switch clears a table.
  function automatic logic [31:0] pick_time();
    int unsigned ws;
    logic [31:0] t;
    ws = (sb.win_len == 0) ? 1 : sb.win_len;
    if ($urandom_range(99) < 2) return ws * $urandom_range(65535);
    t = $urandom;
    if (sb.seen_time && (t % ws) == 0 && t != sb.last_switch) t = sb.last_switch;
    return t;
  endfunction

  // Random transaction: mostly view events over a small key set, some noise and reads.
  function automatic rec_t pick_rec();
    int sel;
    int unsigned nb;
    logic [13:0] rb;
    logic [63:0] key;
    sel = $urandom_range(99);
    nb = sb.eff_buckets();
    key = ($urandom_range(3) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(7)];
    if (sel < 25) begin
      rb = 14'($urandom);
      if (rb < nb && !sb.written[sb.cur_table*NBKT + rb]) begin
        if (sb.last_bucket >= 0) rb = 14'(sb.last_bucket);
        else if (nb < NBKT) rb = 14'(nb);
      end
      if (rb >= nb || sb.written[sb.cur_table*NBKT + rb])
        return mk_rec(KIND_READ, $urandom, {$urandom, $urandom}, $urandom, rb);
    end
    if (sel >= 25 && sel < 40)
      return mk_rec(KIND_EVENT, $urandom ^ 32'h1, key, $urandom, 14'($urandom));
    return mk_rec(KIND_EVENT, VIEW, key, pick_time(), 14'($urandom));
  endfunction

  task automatic run_random(int n);
    repeat (n) send_rec(pick_rec());
  endtask

  // Main sequence: directed checks, then randomized phases over several settings.
  initial begin
    sb = new();
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = KIND_EVENT;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WINDOW;
    cfg_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reads before any count, first view, filter, key and time extremes.
    send_rec(mk_rec(KIND_READ, 32'h0, 64'h0, 32'h0, 14'h3FFF));
    send_rec(mk_rec(KIND_EVENT, 32'h0, 64'h0, 32'h0, 14'h0));
    send_rec(mk_rec(KIND_EVENT, VIEW ^ 32'h8000_0000, '1, '1, '1));
    send_rec(mk_rec(KIND_EVENT, VIEW, 64'h0, 32'd7, 14'h0));
    send_rec(mk_rec(KIND_READ, 32'h0, 64'h0, 32'h0, 14'd321));
    send_rec(mk_rec(KIND_EVENT, VIEW, 64'h0, 32'd7, 14'h0));
    send_rec(mk_rec(KIND_EVENT, VIEW, '1, 32'd7, 14'h0));
    send_rec(mk_rec(KIND_EVENT, VIEW, '1, 32'd7, 14'h0));
    // Same time as the last switch does not open a window; a new multiple does.
    send_rec(mk_rec(KIND_EVENT, VIEW, 64'h0, 32'd10, 14'h0));
    send_rec(mk_rec(KIND_READ, 32'h0, 64'h0, 32'h0, 14'd321));
    send_rec(mk_rec(KIND_EVENT, VIEW, 64'h0, 32'd10, 14'h0));
    send_rec(mk_rec(KIND_EVENT, VIEW, 64'd12345, 32'hFFFF_FFFF, 14'h0));
    send_rec(mk_rec(KIND_EVENT, VIEW, 64'h0, 32'd0, 14'h0));
    send_rec(mk_rec(KIND_READ, 32'h0, 64'h0, 32'h0, 14'd321));
    send_rec(mk_rec(KIND_READ, 32'h0, 64'h0, 32'h0, 14'd9999));
    send_rec(mk_rec(KIND_READ, 32'h0, 64'h0, 32'h0, 14'd10000));

    // Long output hold-off while the sender keeps offering.
    hold_req = 1'b1;
    run_random(80);
    drain();

    // Phase: one bucket, one-second windows, sender idling.
    write_reg(REG_WINDOW, 16'd1);
    write_reg(REG_BUCKETS, 16'd1);
    send_idle_pct = 75;
    recv_stall_pct = 0;
    send_rec(mk_rec(KIND_READ, 32'h0, 64'h0, 32'h0, 14'd1));
    run_random(70);
    drain();

    // Phase: largest settings, receiver stalling.
    write_reg(REG_WINDOW, 16'hFFFF);
    write_reg(REG_BUCKETS, 16'd16384);
    send_idle_pct = 0;
    recv_stall_pct = 75;
    send_rec(mk_rec(KIND_READ, 32'h0, 64'h0, 32'h0, 14'h3FFF));
    run_random(80);
    drain();

    // Phase: zero settings, taken as one, both sides idling.
    write_reg(REG_WINDOW, 16'd0);
    write_reg(REG_BUCKETS, 16'd0);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    run_random(70);
    drain();

    // Phase: bucket count above the supported maximum.
    write_reg(REG_WINDOW, 16'd7);
    write_reg(REG_BUCKETS, 16'd30000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(90);
    drain();

    // Phase: few buckets, short windows, mixed idling.
    write_reg(REG_WINDOW, 16'd3);
    write_reg(REG_BUCKETS, 16'd50);
    send_idle_pct = 10;
    recv_stall_pct = 75;
    run_random(90);
    drain();

    $display("Checked %0d results: %0d view events, %0d reads, %0d window switches.",
             sb.n_checked, sb.n_views, sb.n_reads, sb.n_switches);
    $display("Covered six register settings including zero and out-of-range values.");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
